/* rtl/signed_int_to_decimal_text_assert.svh */
// Assertion macros for the RTL files; sitdt_back is the one that includes them.
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_ASSERT_SVH

// Property checked at every edge outside reset.
`define SITDT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define SITDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sitdt_pkg.sv */
// ----------------------------------------------------------------------------
// sitdt_pkg
// Shared constants and types for the integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitdt_pkg;

	localparam int ValueW    = 32;
	localparam int DigitW    = 4;
	localparam int MaxDigits = 10;
	localparam int CntW      = 4;
	localparam int CharW     = 6;

	localparam logic [CharW-1:0] CharMinus = 6'd45;
	localparam logic [CharW-1:0] CharZero  = 6'd48;
	localparam logic [CharW-1:0] CharNine  = 6'd57;

	// ceil(2^35 / 10): exact quotient by ten for any 32-bit magnitude
	localparam logic [ValueW-1:0] Recip10      = 32'hCCCC_CCCD;
	localparam int                Recip10Shift = 35;

	localparam int QueueDepthDef = 2;

	typedef struct packed {
		logic                             neg;
		logic [CntW-1:0]                  ndig;
		logic [MaxDigits-1:0][DigitW-1:0] digits;  // least significant at index 0
	} dec_entry_t;

endpackage

/* rtl/sitdt_front.sv */
// ----------------------------------------------------------------------------
// sitdt_front
// Takes a signed word, forms its magnitude and peels off one decimal digit a
// cycle by reciprocal multiplication; hands the digit set to the queue.
// ----------------------------------------------------------------------------
module sitdt_front
	import sitdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ValueW-1:0] value,
	input  logic              push,
	output logic              full,
	output logic              q_push,
	output dec_entry_t        q_entry,
	input  logic              q_full
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_HOLD = 3'b100
	} front_state_t;

	front_state_t                     state_q;
	logic [ValueW-1:0]                mag_q;
	logic                             neg_q;
	logic [CntW-1:0]                  cnt_q;
	logic [MaxDigits-1:0][DigitW-1:0] buf_q;
	dec_entry_t                       hold_q;

	logic [2*ValueW-1:0]                 prod;
	logic [2*ValueW-Recip10Shift-1:0]    quo;
	logic [DigitW-1:0]                   q10_lo;
	logic [DigitW-1:0]                   rem;
	logic                                last_dig;
	dec_entry_t                          new_entry;
	logic                                accept;

	assign accept = push && (state_q == F_IDLE);
	assign full   = (state_q != F_IDLE);

	assign prod   = (2*ValueW)'(mag_q) * (2*ValueW)'(Recip10);
	assign quo    = prod[2*ValueW-1:Recip10Shift];
	// remainder fits in four bits, so only the low bits of quo*10 matter
	assign q10_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};
	assign rem    = mag_q[DigitW-1:0] - q10_lo;

	assign last_dig = (quo == '0) || (cnt_q == CntW'(MaxDigits - 1));

	always_comb begin
		new_entry.neg  = neg_q;
		new_entry.ndig = cnt_q + CntW'(1);
		for (int i = 0; i < MaxDigits; i++) begin
			new_entry.digits[i] = (cnt_q == CntW'(i)) ? rem : buf_q[i];
		end
	end

	assign q_push  = ((state_q == F_CONV) && last_dig && !q_full) ||
	                 ((state_q == F_HOLD) && !q_full);
	assign q_entry = (state_q == F_HOLD) ? hold_q : new_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) state_q <= F_CONV;
				end
				F_CONV: begin
					if (last_dig) state_q <= q_full ? F_HOLD : F_IDLE;
				end
				F_HOLD: begin
					if (!q_full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value[ValueW-1];
			// negating the most negative value wraps to its own magnitude
			mag_q <= value[ValueW-1] ? (~value + ValueW'(1)) : value;
			cnt_q <= '0;
		end else if (state_q == F_CONV) begin
			buf_q[cnt_q] <= rem;
			mag_q        <= ValueW'(quo);
			cnt_q        <= cnt_q + CntW'(1);
			hold_q       <= new_entry;
		end
	end

endmodule

/* rtl/sitdt_queue.sv */
// ----------------------------------------------------------------------------
// sitdt_queue
// Small register queue of converted digit sets between front and back.
// ----------------------------------------------------------------------------
module sitdt_queue
	import sitdt_pkg::*;
#(
	parameter int DEPTH = QueueDepthDef
)(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  dec_entry_t wr_entry,
	output logic       full,
	input  logic       pop,
	output dec_entry_t rd_entry,
	output logic       empty
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int OccW = $clog2(DEPTH + 1);

	dec_entry_t        mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [OccW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == OccW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + OccW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - OccW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

/* rtl/sitdt_back.sv */
// ----------------------------------------------------------------------------
// sitdt_back
// Walks a digit set, minus sign first, then digits most significant first, and
// writes one character a cycle into the output register while it is free or being drained.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_text_assert.svh"

module sitdt_back
	import sitdt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  dec_entry_t       q_entry,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [CharW-1:0] char_code,
	output logic             last
);

	logic                             busy_q;
	logic                             sign_pend_q;
	logic [CntW-1:0]                  idx_q;
	logic [MaxDigits-1:0][DigitW-1:0] digits_q;

	logic             valid_q;
	logic [CharW-1:0] char_q;
	logic             last_q;

	logic             adv;
	logic             take;
	logic             cur_last;
	logic [CharW-1:0] cur_char;

	assign cur_last = !sign_pend_q && (idx_q == '0);
	assign cur_char = sign_pend_q ? CharMinus
	                              : CharZero + CharW'(digits_q[idx_q]);

	// advance whenever the output register is free or being drained
	assign adv   = busy_q && (!valid_q || pop);
	assign take  = !q_empty && (!busy_q || (adv && cur_last));
	assign q_pop = take;

	assign empty     = !valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
			end else if (adv && cur_last) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sign_pend_q <= q_entry.neg;
			idx_q       <= q_entry.ndig - CntW'(1);
			digits_q    <= q_entry.digits;
		end else if (adv) begin
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else begin
				idx_q <= idx_q - CntW'(1);
			end
		end
		if (adv) begin
			char_q <= cur_char;
			last_q <= cur_last;
		end
	end

	`SITDT_ASSERT(a_char_legal, clk, arst_n, (valid_q |-> (char_q == CharMinus || (char_q >= CharZero && char_q <= CharNine))), "illegal character in output word")
	`SITDT_ASSERT(a_idx_range, clk, arst_n, (busy_q |-> (idx_q < CntW'(MaxDigits))), "digit index out of range")
	`SITDT_ASSERT_NEXT(a_last_ends_run, clk, arst_n, (adv && cur_last && !take), (!busy_q), "run still busy after last character")

endmodule

/* rtl/signed_int_to_decimal_text.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text
// Signed 32-bit integer to decimal ASCII text, one character per output word.
// ----------------------------------------------------------------------------
// Input channel: write value with push while full is low. Output channel: a
// character sits on char_code/last while empty is low and leaves on pop. Each
// integer gives a run of 1 to 11 words, minus sign first for negative values,
// then digits most significant first; last marks the final word.
// The front converter takes one integer, then peels off its decimal digits,
// least significant first, by a 32x32 reciprocal multiply by ten; full stays
// high until the digit set is handed on, so no new integer is taken while it
// converts. The back emits one word per cycle while its output register is
// free or being drained. A queue (two entries by default) between front and
// back lets the front keep converting while the back is held by a stalled
// receiver; once the queue fills, full stays high. Output words are never
// dropped while pop is low.
// Reset clears the queue, the converter state and the output register; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text
	import sitdt_pkg::*;
#(
	parameter int QUEUE_DEPTH = QueueDepthDef
)(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [ValueW-1:0] value,
	input  logic                     push,
	output logic                     full,
	output logic [CharW-1:0]         char_code,
	output logic                     last,
	output logic                     empty,
	input  logic                     pop
);

	logic       fq_push;
	dec_entry_t fq_wr_entry;
	logic       fq_full;
	logic       bq_pop;
	dec_entry_t bq_rd_entry;
	logic       bq_empty;

	sitdt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.value   (value),
		.push    (push),
		.full    (full),
		.q_push  (fq_push),
		.q_entry (fq_wr_entry),
		.q_full  (fq_full)
	);

	sitdt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fq_push),
		.wr_entry (fq_wr_entry),
		.full     (fq_full),
		.pop      (bq_pop),
		.rd_entry (bq_rd_entry),
		.empty    (bq_empty)
	);

	sitdt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (bq_empty),
		.q_entry   (bq_rd_entry),
		.q_pop     (bq_pop),
		.empty     (empty),
		.pop       (pop),
		.char_code (char_code),
		.last      (last)
	);

endmodule

/* dv/signed_int_to_decimal_text_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text_tb
// Self-checking bench for the integer to decimal text converter: a directed
// table of edge values, then random integers of every length, each word on
// the output checked against a given string or a local model of the
// conversion, with both sides of the interface stalling at random in all but the last phase.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_tb;
	import sitdt_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 20;
	localparam int RandomItems = 198;

	typedef struct {
		logic [CharW-1:0] char_code;
		logic             last;
	} text_word_t;

	typedef struct {
		logic signed [ValueW-1:0] value;
		string                    text;  // empty: model works it out
	} table_row_t;

	localparam int TableRows = 21;

	table_row_t table_rows [0:TableRows-1] = '{
		'{32'sd0,          "0"},
		'{32'sd1,          ""},
		'{32'hFFFF_FFFF,   "-1"},
		'{32'sd9,          ""},
		'{32'sd10,         ""},
		'{32'hFFFF_FFF7,   ""},
		'{32'hFFFF_FFF6,   ""},
		'{32'sd99,         ""},
		'{32'sd100,        ""},
		'{32'sd999999999,  ""},
		'{32'sd1000000000, ""},
		'{32'hC465_3600,   ""},
		'{32'h7FFF_FFFF,   "2147483647"},
		'{32'h8000_0000,   "-2147483648"},
		'{32'h8000_0001,   ""},
		'{32'h7FFF_FFFE,   ""},
		'{32'sd123456789,  ""},
		'{32'hC521_974F,   ""},
		'{32'h5555_5555,   ""},
		'{32'hAAAA_AAAA,   ""},
		'{32'sd0,          ""}
	};

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic signed [ValueW-1:0] value = '0;
	logic                     push = 1'b0;
	logic                     full;
	logic [CharW-1:0]         char_code;
	logic                     last;
	logic                     empty;
	logic                     pop = 1'b0;

	text_word_t text_due [$];
	int         faults = 0;
	int         cycles = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;

	signed_int_to_decimal_text uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.push      (push),
		.full      (full),
		.char_code (char_code),
		.last      (last),
		.empty     (empty),
		.pop       (pop)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d words still due", cycles, text_due.size());
			$display("** signed_int_to_decimal_text: FAILED **");
			$finish;
		end
	end

	function automatic void note_fault(string msg);
		faults++;
		if (faults <= 10)
			$display("mismatch: %s", msg);
	endfunction

	// Decimal text of one integer, sign first, digits most significant first
	function automatic void predict_text(logic signed [ValueW-1:0] v);
		logic [CharW-1:0] digits [$];
		longint unsigned  mag;
		bit               neg;
		int               total;
		text_word_t       w;
		neg = v[ValueW-1];
		// widen before negating so the most negative value survives
		mag = neg ? (64'd1 << ValueW) - {32'd0, v} : {32'd0, v};
		do begin
			digits.push_front(CharZero + CharW'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (neg)
			digits.push_front(CharMinus);
		total = digits.size();
		for (int i = 0; i < total; i++) begin
			w.char_code = digits[i];
			w.last      = (i == total - 1);
			text_due.push_back(w);
		end
	endfunction

	task automatic send_word(logic signed [ValueW-1:0] v, string text);
		text_word_t w;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
		if (text.len() == 0) begin
			predict_text(v);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				w.char_code = CharW'(text[i]);
				w.last      = (i == text.len() - 1);
				text_due.push_back(w);
			end
		end
	endtask

	// hold the input off until every due word has left
	task automatic drain_pause();
		push <= 1'b0;
		do @(posedge clk); while (text_due.size() != 0);
	endtask

	initial begin
		text_word_t w;
		wait (arst_n === 1'b1);
		forever begin
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			@(posedge clk);
			if (pop && !empty) begin
				if (text_due.size() == 0) begin
					note_fault($sformatf("word char=%0d last=%0d with nothing due",
						char_code, last));
				end else begin
					w = text_due.pop_front();
					if (char_code !== w.char_code)
						note_fault($sformatf("char_code expected %0d got %0d",
							w.char_code, char_code));
					if (last !== w.last)
						note_fault($sformatf("last expected %0d got %0d (char %0d)",
							w.last, last, w.char_code));
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 65;
		for (int r = 0; r < TableRows; r++)
			send_word(table_rows[r].value, table_rows[r].text);
		drain_pause();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 34; recv_idle_pct = 65; end
				1: begin send_idle_pct = 65; recv_idle_pct = 34; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int n = 0; n < RandomItems / 3; n++) begin
				logic signed [ValueW-1:0] v;
				longint                   lo;
				longint                   hi;
				longint                   mag;
				int unsigned              ndig;
				case ($urandom_range(0, 3))
					0: v = $urandom;
					1: begin
						// magnitude of a chosen digit count, either sign
						ndig = $urandom_range(1, 10);
						lo = 1;
						repeat (ndig - 1) lo = lo * 10;
						hi = lo * 10 - 1;
						if (hi > 64'sd2147483647)
							hi = 64'sd2147483647;
						if (ndig == 1)
							lo = 0;
						mag = lo + longint'($urandom) % (hi - lo + 1);
						v = $urandom_range(0, 1) ? ValueW'(-mag) : ValueW'(mag);
					end
					2: begin
						case ($urandom_range(0, 2))
							0: v = 32'h7FFF_FFFF - $urandom_range(0, 15);
							1: v = 32'h8000_0000 + $urandom_range(0, 15);
							default: v = $urandom_range(0, 20) - 10;
						endcase
					end
					default: begin
						// power of ten, give or take one
						mag = 1;
						repeat ($urandom_range(0, 9)) mag = mag * 10;
						mag = mag + $urandom_range(0, 2) - 1;
						v = $urandom_range(0, 1) ? ValueW'(-mag) : ValueW'(mag);
					end
				endcase
				send_word(v, "");
			end
			drain_pause();
		end

		push <= 1'b0;
		while (text_due.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (text_due.size() != 0)
			note_fault($sformatf("%0d words never arrived", text_due.size()));
		if (faults == 0)
			$display("** signed_int_to_decimal_text: PASSED **");
		else
			$display("** signed_int_to_decimal_text: FAILED **");
		$finish;
	end

endmodule
